>>> rtl/core/semg_pkg.sv
// Shared types and constants for the servo eased move generator.
// Used by the serial multiplier, the serial divider and the top level.
package semg_pkg;

  localparam int SERVO_NUM = 4;
  localparam int ANG_W     = 8;
  localparam int STEP_W    = 13;
  localparam int MUL_A_W   = 39;
  localparam int MUL_B_W   = 13;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int DIV_W     = 50;
  localparam int QUO_W     = 9;

  localparam logic [ANG_W-1:0] ANG_MAX  = 8'd180;
  localparam logic [ANG_W-1:0] ANG_HOME = 8'd90;
  localparam logic [15:0] HOME_BASE_MS  = 16'd500;
  localparam logic [15:0] HOME_MAX_MS   = 16'd1700;
  localparam logic [15:0] HOME_SLOPE    = 16'd9;
  localparam logic [15:0] TICK_MS       = 16'd10;
  // floor(x/10) == (x * RECIP10) >> RECIP10_SH for every 16-bit x.
  localparam logic [16:0] RECIP10       = 17'd52429;
  localparam int RECIP10_SH             = 19;

  typedef enum logic [2:0] {
    REQ_MOVE   = 3'd0,
    REQ_TICK   = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_HOME   = 3'd3,
    REQ_SINGLE = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_R2,
    S_R3,
    S_N2,
    S_N3,
    S_MM,
    S_DV,
    S_DONE
  } state_t;

  // Absolute difference between two angles.
  function automatic logic [ANG_W-1:0] ang_dist(input logic [ANG_W-1:0] a,
                                                input logic [ANG_W-1:0] b);
    logic [ANG_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

>>> rtl/core/semg_mul.sv
// Shift-add multiplier that takes one multiplier bit per cycle.
// Depends on semg_pkg for operand widths.
module semg_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start_i,
  input  logic [semg_pkg::MUL_A_W-1:0]     a_i,
  input  logic [semg_pkg::MUL_B_W-1:0]     b_i,
  output logic                             done_o,
  output logic [semg_pkg::MUL_P_W-1:0]     prod_o
);

  localparam int CNT_W = $clog2(semg_pkg::MUL_B_W + 1);

  logic [semg_pkg::MUL_P_W-1:0] acc_r;
  logic [semg_pkg::MUL_P_W-1:0] a_r;
  logic [semg_pkg::MUL_B_W-1:0] b_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         done_r;

  // Control: bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start_i) begin
      cnt_r  <= CNT_W'(semg_pkg::MUL_B_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Datapath: add the shifted multiplicand when the low multiplier bit is set.
  always_ff @(posedge clk) begin
    if (start_i) begin
      acc_r <= '0;
      a_r   <= semg_pkg::MUL_P_W'(a_i);
      b_r   <= b_i;
    end else if (cnt_r != '0) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= {a_r[semg_pkg::MUL_P_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[semg_pkg::MUL_B_W-1:1]};
    end
  end

  assign done_o = done_r;
  assign prod_o = acc_r;

endmodule

>>> rtl/core/semg_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on semg_pkg for widths; the quotient is known to fit QUO_W bits.
module semg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start_i,
  input  logic [semg_pkg::DIV_W-1:0]     num_i,
  input  logic [semg_pkg::DIV_W-1:0]     den_i,
  output logic                           done_o,
  output logic [semg_pkg::QUO_W-1:0]     quo_o
);

  localparam int CNT_W = $clog2(semg_pkg::QUO_W + 1);

  logic [semg_pkg::DIV_W-1:0] rem_r;
  logic [semg_pkg::DIV_W-1:0] dsh_r;
  logic [semg_pkg::QUO_W-1:0] quo_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       done_r;
  logic                       fit;

  assign fit = (rem_r >= dsh_r);

  // Control: quotient bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start_i) begin
      cnt_r  <= CNT_W'(semg_pkg::QUO_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Datapath: trial subtract of the shifted divisor, most significant bit first.
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= num_i;
      dsh_r <= den_i << (semg_pkg::QUO_W - 1);
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      if (fit) rem_r <= rem_r - dsh_r;
      quo_r <= {quo_r[semg_pkg::QUO_W-2:0], fit};
      dsh_r <= {1'b0, dsh_r[semg_pkg::DIV_W-1:1]};
    end
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

>>> rtl/core/servo_eased_move_generator.sv
// Top level of the four-servo eased move generator.
// Depends on semg_pkg, semg_mul and semg_div.
//
// Each accepted item yields one result item. Every item but a tick inside an
// eased move goes from idle straight to the done state. A tick inside an eased
// move first runs the serial units: a bit-serial multiplier forms (N-k)^3 and N^3
// with four multiplies, then for each of the four servos scales the cube by the
// angle distance and a one bit per cycle divider rounds the ratio. The next item
// is taken as soon as the result is handed to the output register, even while it
// waits there.
module servo_eased_move_generator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [15:0]       in_duration_ms,
  input  logic [7:0]        in_target_a,
  input  logic [7:0]        in_target_b,
  input  logic [7:0]        in_target_c,
  input  logic [7:0]        in_target_d,
  input  logic [2:0]        in_servo_index,
  input  logic signed [8:0] in_single_angle,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_angle_a,
  output logic [7:0]        out_angle_b,
  output logic [7:0]        out_angle_c,
  output logic [7:0]        out_angle_d,
  output logic              out_moving,
  output logic              out_finished,
  output logic              out_stop_pending,
  output logic              out_at_rest,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_enabled_mask
);

  localparam int NS = semg_pkg::SERVO_NUM;
  localparam int AW = semg_pkg::ANG_W;
  localparam int SW = semg_pkg::STEP_W;

  semg_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] cur_r   [NS];
  logic [AW-1:0] start_r [NS];
  logic [AW-1:0] goal_r  [NS];
  logic [SW-1:0] n_r, step_r, r_r;
  logic [NS-1:0] mask_r;
  logic          busy_r, stop_r, rest_r, homing_r, done_r;
  logic [1:0]    idx_r;
  logic [38:0]   n3_r, r3_r;

  logic [AW-1:0] out_ang_r [NS];
  logic          out_valid_r, out_moving_r, out_fin_r, out_stop_r, out_rest_r;

  logic                             mul_start, mul_done, div_start, div_done;
  logic [semg_pkg::MUL_A_W-1:0]     mul_a;
  logic [semg_pkg::MUL_B_W-1:0]     mul_b;
  logic [semg_pkg::MUL_P_W-1:0]     mul_prod;
  logic [semg_pkg::DIV_W-1:0]       div_num, div_den;
  logic [semg_pkg::QUO_W-1:0]       div_quo;

  logic          accept, out_load;
  logic [AW-1:0] tgt [NS];
  logic [AW-1:0] sat [NS];
  logic [AW-1:0] md;
  logic [15:0]   hd, bm_dur;
  logic [32:0]   recip;
  logic [SW-1:0] bm_n, k_now, r_now;
  logic          tick_eased;
  logic [1:0]    idx_sel;
  logic [AW-1:0] mag;
  logic          up_cur;
  logic [AW-1:0] new_ang;
  logic [AW-1:0] sing_ang;
  semg_pkg::req_t req;

  assign req       = semg_pkg::req_t'(in_req_type);
  assign in_ready  = (state_r == semg_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == semg_pkg::S_DONE) && (!out_valid_r || out_ready);

  assign tgt[0] = in_target_a;
  assign tgt[1] = in_target_b;
  assign tgt[2] = in_target_c;
  assign tgt[3] = in_target_d;

  // Request decode: saturated targets, home duration and step count.
  always_comb begin
    md = '0;
    for (int i = 0; i < NS; i++) begin
      sat[i] = (tgt[i] > semg_pkg::ANG_MAX) ? semg_pkg::ANG_MAX : tgt[i];
      if (mask_r[i] && (semg_pkg::ang_dist(cur_r[i], semg_pkg::ANG_HOME) > md))
        md = semg_pkg::ang_dist(cur_r[i], semg_pkg::ANG_HOME);
    end
    hd = semg_pkg::HOME_BASE_MS + semg_pkg::HOME_SLOPE * 16'(md);
    if (hd > semg_pkg::HOME_MAX_MS) hd = semg_pkg::HOME_MAX_MS;
    bm_dur = (req == semg_pkg::REQ_HOME) ? hd : in_duration_ms;
    recip  = 33'(bm_dur) * 33'(semg_pkg::RECIP10);
    bm_n   = recip[semg_pkg::RECIP10_SH +: SW];
  end

  // Tick decode: step index and remaining steps.
  assign k_now      = step_r + SW'(1);
  assign r_now      = n_r - k_now;
  assign tick_eased = (req == semg_pkg::REQ_TICK) && busy_r && !stop_r && (k_now < n_r);

  // Single set angle: out of range values become the home angle.
  assign sing_ang = (in_single_angle < 0 || in_single_angle > 9'sd180) ?
                    semg_pkg::ANG_HOME : in_single_angle[AW-1:0];

  // Distance for the servo now being scaled.
  assign idx_sel = (state_r == semg_pkg::S_DV) ? (idx_r + 2'd1) : idx_r;
  assign mag     = semg_pkg::ang_dist(goal_r[idx_sel], start_r[idx_sel]);
  assign up_cur  = (goal_r[idx_r] >= start_r[idx_r]);
  assign new_ang = up_cur ? (goal_r[idx_r] - div_quo[AW-1:0])
                          : (goal_r[idx_r] + div_quo[AW-1:0]);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= semg_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Sequencer: next state and launches of the serial units.
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      semg_pkg::S_IDLE: begin
        if (accept) begin
          if (tick_eased) begin
            state_nxt = semg_pkg::S_R2;
            mul_start = 1'b1;
            mul_a     = semg_pkg::MUL_A_W'(r_now);
            mul_b     = r_now;
          end else begin
            state_nxt = semg_pkg::S_DONE;
          end
        end
      end
      semg_pkg::S_R2: begin
        if (mul_done) begin
          state_nxt = semg_pkg::S_R3;
          mul_start = 1'b1;
          mul_a     = semg_pkg::MUL_A_W'(mul_prod[25:0]);
          mul_b     = r_r;
        end
      end
      semg_pkg::S_R3: begin
        if (mul_done) begin
          state_nxt = semg_pkg::S_N2;
          mul_start = 1'b1;
          mul_a     = semg_pkg::MUL_A_W'(n_r);
          mul_b     = n_r;
        end
      end
      semg_pkg::S_N2: begin
        if (mul_done) begin
          state_nxt = semg_pkg::S_N3;
          mul_start = 1'b1;
          mul_a     = semg_pkg::MUL_A_W'(mul_prod[25:0]);
          mul_b     = n_r;
        end
      end
      semg_pkg::S_N3: begin
        if (mul_done) begin
          state_nxt = semg_pkg::S_MM;
          mul_start = 1'b1;
          mul_a     = r3_r;
          mul_b     = semg_pkg::MUL_B_W'(mag);
        end
      end
      semg_pkg::S_MM: begin
        // Rounded ratio: down moves round ties up, up moves round ties down.
        if (mul_done) begin
          state_nxt = semg_pkg::S_DV;
          div_start = 1'b1;
          div_num   = {mul_prod[semg_pkg::DIV_W-2:0], 1'b0}
                      + semg_pkg::DIV_W'(n3_r)
                      - semg_pkg::DIV_W'(up_cur);
          div_den   = semg_pkg::DIV_W'({n3_r, 1'b0});
        end
      end
      semg_pkg::S_DV: begin
        if (div_done) begin
          if (idx_r == 2'(NS - 1)) begin
            state_nxt = semg_pkg::S_DONE;
          end else begin
            state_nxt = semg_pkg::S_MM;
            mul_start = 1'b1;
            mul_a     = r3_r;
            mul_b     = semg_pkg::MUL_B_W'(mag);
          end
        end
      end
      semg_pkg::S_DONE: begin
        if (out_load) state_nxt = semg_pkg::S_IDLE;
      end
      default: state_nxt = semg_pkg::S_IDLE;
    endcase
  end

  // Control state: flags, counters and enable mask.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '1;
      n_r      <= '0;
      step_r   <= '0;
      busy_r   <= 1'b0;
      stop_r   <= 1'b0;
      rest_r   <= 1'b0;
      homing_r <= 1'b0;
      done_r   <= 1'b0;
      idx_r    <= '0;
      for (int i = 0; i < NS; i++) cur_r[i] <= semg_pkg::ANG_HOME;
    end else begin
      if (cfg_valid && cfg_ready) mask_r <= cfg_enabled_mask;
      if (accept) begin
        done_r <= 1'b0;
        idx_r  <= '0;
        unique case (req)
          semg_pkg::REQ_MOVE, semg_pkg::REQ_HOME: begin
            rest_r   <= 1'b0;
            homing_r <= 1'b0;
            if (req == semg_pkg::REQ_HOME) stop_r <= 1'b0;
            if (bm_dur <= semg_pkg::TICK_MS) begin
              // Short move: jump straight to the goals.
              for (int i = 0; i < NS; i++)
                if (mask_r[i]) cur_r[i] <= sat[i];
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else begin
              n_r      <= bm_n;
              step_r   <= '0;
              busy_r   <= 1'b1;
              homing_r <= (req == semg_pkg::REQ_HOME);
            end
          end
          semg_pkg::REQ_TICK: begin
            if (busy_r) begin
              if (stop_r) begin
                busy_r   <= 1'b0;
                homing_r <= 1'b0;
                if (homing_r) rest_r <= 1'b1;
              end else begin
                step_r <= k_now;
                if (!tick_eased) begin
                  // Last step lands on the goals.
                  for (int i = 0; i < NS; i++)
                    if (mask_r[i]) cur_r[i] <= goal_r[i];
                  busy_r   <= 1'b0;
                  done_r   <= 1'b1;
                  homing_r <= 1'b0;
                  if (homing_r) rest_r <= 1'b1;
                end
              end
            end
          end
          semg_pkg::REQ_STOP:  stop_r <= 1'b1;
          semg_pkg::REQ_CLEAR: stop_r <= 1'b0;
          semg_pkg::REQ_SINGLE: begin
            rest_r <= 1'b0;
            if (in_servo_index < 3'(NS) && mask_r[in_servo_index[1:0]])
              cur_r[in_servo_index[1:0]] <= sing_ang;
          end
          default: ;
        endcase
      end else if (state_r == semg_pkg::S_DV && div_done) begin
        if (mask_r[idx_r]) cur_r[idx_r] <= new_ang;
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Move endpoints and cubes; no reset, read only while a move is running.
  always_ff @(posedge clk) begin
    if (accept && (req == semg_pkg::REQ_MOVE || req == semg_pkg::REQ_HOME)) begin
      for (int i = 0; i < NS; i++) begin
        start_r[i] <= cur_r[i];
        goal_r[i]  <= (req == semg_pkg::REQ_HOME) ? semg_pkg::ANG_HOME : sat[i];
      end
    end
    if (accept) r_r <= r_now;
    if (mul_done) begin
      unique case (state_r)
        semg_pkg::S_R3: r3_r <= mul_prod[38:0];
        semg_pkg::S_N3: n3_r <= mul_prod[38:0];
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < NS; i++) out_ang_r[i] <= cur_r[i];
      out_moving_r <= busy_r;
      out_fin_r    <= done_r;
      out_stop_r   <= stop_r;
      out_rest_r   <= rest_r;
    end
  end

  semg_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  semg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid        = out_valid_r;
  assign out_angle_a      = out_ang_r[0];
  assign out_angle_b      = out_ang_r[1];
  assign out_angle_c      = out_ang_r[2];
  assign out_angle_d      = out_ang_r[3];
  assign out_moving       = out_moving_r;
  assign out_finished     = out_fin_r;
  assign out_stop_pending = out_stop_r;
  assign out_at_rest      = out_rest_r;

endmodule

>>> rtl/core/semg_checker.sv
// Port-level checks for the servo eased move generator.
// Depends on nothing but the top level's ports; bound to the top level below.
module semg_assertions (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_angle_a,
  input logic [7:0] out_angle_b,
  input logic [7:0] out_angle_c,
  input logic [7:0] out_angle_d,
  input logic       out_moving,
  input logic       out_finished,
  input logic       out_at_rest
);

  // A stalled result item stays valid and keeps its first angle and finished flag.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle_a) && $stable(out_finished))
    else $error("result item changed while stalled");

  // A finished move is no longer in progress.
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_finished && out_moving))
    else $error("finished and moving together");

  // Rest is never reported while a move is in progress.
  a_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_at_rest && out_moving))
    else $error("at rest while moving");

  // Commanded angles stay within the servo range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_a <= 8'd180) && (out_angle_b <= 8'd180) &&
                  (out_angle_c <= 8'd180) && (out_angle_d <= 8'd180))
    else $error("angle out of range");

endmodule

bind servo_eased_move_generator semg_assertions u_semg_assertions (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_angle_a  (out_angle_a),
  .out_angle_b  (out_angle_b),
  .out_angle_c  (out_angle_c),
  .out_angle_d  (out_angle_d),
  .out_moving   (out_moving),
  .out_finished (out_finished),
  .out_at_rest  (out_at_rest)
);

>>> bench/semg_checker.sv
// Checker for the servo eased move generator: watches all three channels,
// predicts every result item and compares it with what the block sends.
// Depends on semg_pkg for the request codes and the servo count.
`timescale 1ns / 100ps

module semg_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [15:0]       in_duration_ms,
  input  logic [7:0]        in_target_a,
  input  logic [7:0]        in_target_b,
  input  logic [7:0]        in_target_c,
  input  logic [7:0]        in_target_d,
  input  logic [2:0]        in_servo_index,
  input  logic signed [8:0] in_single_angle,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_angle_a,
  input  logic [7:0]        out_angle_b,
  input  logic [7:0]        out_angle_c,
  input  logic [7:0]        out_angle_d,
  input  logic              out_moving,
  input  logic              out_finished,
  input  logic              out_stop_pending,
  input  logic              out_at_rest,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [3:0]        cfg_enabled_mask,
  output int                error_count,
  output int                pending_count
);

  typedef struct packed {
    logic [7:0] a, b, c, d;
    logic       moving, finished, stop, rest;
  } servo_status_t;

  servo_status_t status_q[$];

  // Model state of the generator.
  logic [3:0]  mask;
  logic [7:0]  cur_ang  [semg_pkg::SERVO_NUM];
  logic [7:0]  from_ang [semg_pkg::SERVO_NUM];
  logic [7:0]  to_ang   [semg_pkg::SERVO_NUM];
  logic [12:0] n_steps, k_steps;
  logic        busy, stop_req, resting, homing;

  assign pending_count = status_q.size();

  // Angle of servo i at step k of the eased path, rounded half up.
  function automatic logic [7:0] ease_angle(int i, logic [12:0] k);
    logic [63:0] g, s, r, den, mag, m, q;
    g   = to_ang[i];
    s   = from_ang[i];
    r   = n_steps - k;
    den = 64'(n_steps) * n_steps * n_steps;
    mag = (g >= s) ? g - s : s - g;
    m   = mag * r * r * r;
    if (g >= s) begin
      q = (2 * m + den - 1) / (2 * den);
      return 8'(g - q);
    end
    q = (2 * m + den) / (2 * den);
    return 8'(g + q);
  endfunction

  // Start a move; short durations jump straight to the goals.
  task automatic start_move(logic [15:0] dur, logic [7:0] goals [semg_pkg::SERVO_NUM],
                            logic home, ref logic done);
    resting = 1'b0;
    homing  = 1'b0;
    if (dur <= 16'd10) begin
      for (int i = 0; i < semg_pkg::SERVO_NUM; i++)
        if (mask[i]) cur_ang[i] = goals[i];
      busy = 1'b0;
      done = 1'b1;
      return;
    end
    for (int i = 0; i < semg_pkg::SERVO_NUM; i++) begin
      from_ang[i] = cur_ang[i];
      to_ang[i]   = goals[i];
    end
    n_steps = 13'(dur / 10);
    k_steps = '0;
    busy    = 1'b1;
    homing  = home;
  endtask

  task automatic predict_status();
    logic [7:0]  goals [semg_pkg::SERVO_NUM];
    logic [7:0]  tg    [semg_pkg::SERVO_NUM];
    logic        done;
    int          md, dl, hd, ang;
    servo_status_t st;
    done = 1'b0;
    tg[0] = in_target_a; tg[1] = in_target_b; tg[2] = in_target_c; tg[3] = in_target_d;
    case (in_req_type)
      semg_pkg::REQ_MOVE: begin
        for (int i = 0; i < semg_pkg::SERVO_NUM; i++)
          goals[i] = (tg[i] > 8'd180) ? 8'd180 : tg[i];
        start_move(in_duration_ms, goals, 1'b0, done);
      end
      semg_pkg::REQ_TICK: begin
        if (busy) begin
          if (stop_req) begin
            busy = 1'b0;
            if (homing) resting = 1'b1;
            homing = 1'b0;
          end else begin
            k_steps = k_steps + 13'd1;
            for (int i = 0; i < semg_pkg::SERVO_NUM; i++)
              if (mask[i]) cur_ang[i] = ease_angle(i, k_steps);
            if (k_steps >= n_steps) begin
              for (int i = 0; i < semg_pkg::SERVO_NUM; i++)
                if (mask[i]) cur_ang[i] = to_ang[i];
              busy = 1'b0;
              done = 1'b1;
              if (homing) resting = 1'b1;
              homing = 1'b0;
            end
          end
        end
      end
      semg_pkg::REQ_STOP: stop_req = 1'b1;
      semg_pkg::REQ_HOME: begin
        md = 0;
        stop_req = 1'b0;
        for (int i = 0; i < semg_pkg::SERVO_NUM; i++) begin
          dl = (cur_ang[i] >= 8'd90) ? cur_ang[i] - 90 : 90 - cur_ang[i];
          goals[i] = 8'd90;
          if (mask[i] && dl > md) md = dl;
        end
        hd = 500 + 9 * md;
        if (hd > 1700) hd = 1700;
        start_move(16'(hd), goals, 1'b1, done);
      end
      semg_pkg::REQ_SINGLE: begin
        ang = in_single_angle;
        if (ang < 0 || ang > 180) ang = 90;
        resting = 1'b0;
        if (in_servo_index < semg_pkg::SERVO_NUM && mask[in_servo_index])
          cur_ang[in_servo_index] = 8'(ang);
      end
      semg_pkg::REQ_CLEAR: stop_req = 1'b0;
      default: ;
    endcase
    st = '{cur_ang[0], cur_ang[1], cur_ang[2], cur_ang[3], busy, done, stop_req, resting};
    status_q.push_back(st);
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Track every handshake at the rising edge; inputs are predicted first so
  // the queue order stays right when both channels move in one cycle.
  always @(posedge clk) begin
    servo_status_t e;
    if (!rst_n) begin
      error_count = 0;
      mask = 4'hF;
      for (int i = 0; i < semg_pkg::SERVO_NUM; i++) begin
        cur_ang[i] = 8'd90; from_ang[i] = '0; to_ang[i] = '0;
      end
      n_steps = '0; k_steps = '0;
      busy = 1'b0; stop_req = 1'b0; resting = 1'b0; homing = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) mask = cfg_enabled_mask;
      if (in_valid && in_ready) predict_status();
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          error_count++;
        end else begin
          e = status_q.pop_front();
          check_field("angle_a", e.a, out_angle_a);
          check_field("angle_b", e.b, out_angle_b);
          check_field("angle_c", e.c, out_angle_c);
          check_field("angle_d", e.d, out_angle_d);
          check_field("moving", e.moving, out_moving);
          check_field("finished", e.finished, out_finished);
          check_field("stop_pending", e.stop, out_stop_pending);
          check_field("at_rest", e.rest, out_at_rest);
        end
      end
    end
  end

endmodule

>>> bench/tb.sv
// Top of the servo eased move generator testbench: clock, reset, stimulus,
// configuration phases and the verdict. Depends on semg_pkg and semg_checker.
`timescale 1ns / 100ps

module tb;

  localparam int IDLE_LIMIT = 4000;

  logic              clk, rst_n;
  logic              in_valid, in_ready;
  logic [2:0]        in_req_type;
  logic [15:0]       in_duration_ms;
  logic [7:0]        in_target_a, in_target_b, in_target_c, in_target_d;
  logic [2:0]        in_servo_index;
  logic signed [8:0] in_single_angle;
  logic              out_valid, out_ready;
  logic [7:0]        out_angle_a, out_angle_b, out_angle_c, out_angle_d;
  logic              out_moving, out_finished, out_stop_pending, out_at_rest;
  logic              cfg_valid, cfg_ready;
  logic [3:0]        cfg_enabled_mask;
  int                error_count, pending_count;
  int                sent_items;
  logic              long_hold_req;

  servo_eased_move_generator uut (.*);

  semg_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too many cycles with no handshake on any channel.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: a random hold-off per item, and one long stall on request.
  initial begin
    int w;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      w = (long_hold_req) ? 400 : $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0 && !long_hold_req) w = 0;
      long_hold_req = 1'b0;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one request item after a random gap and wait until it is taken.
  task automatic send_req(logic [2:0] req, logic [15:0] dur, logic [7:0] ta, logic [7:0] tb_,
                          logic [7:0] tc, logic [7:0] td, logic [2:0] idx,
                          logic [8:0] ang);
    int gap;
    gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type     <= req;
    in_duration_ms  <= dur;
    in_target_a     <= ta;
    in_target_b     <= tb_;
    in_target_c     <= tc;
    in_target_d     <= td;
    in_servo_index  <= idx;
    in_single_angle <= ang;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic send_simple(logic [2:0] req);
    send_req(req, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 3'($urandom), 9'($urandom));
  endtask

  task automatic send_move(logic [15:0] dur);
    send_req(semg_pkg::REQ_MOVE, dur, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 3'($urandom), 9'($urandom));
  endtask

  // Write the enable mask once the block has drained.
  task automatic write_mask(logic [3:0] m);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_enabled_mask <= m;
    cfg_valid        <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random stretch: mostly eased moves followed by ticks.
  task automatic random_sequence();
    int kind, n, ticks;
    logic [15:0] dur;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      dur = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(150, 65535))
                                         : 16'($urandom_range(11, 150));
      send_move(dur);
      n = dur / 10;
      ticks = n + $urandom_range(0, 2);
      if (ticks > 20) ticks = $urandom_range(1, 20);
      for (int t = 0; t < ticks; t++) begin
        case ($urandom_range(0, 29))
          0: send_simple(semg_pkg::REQ_STOP);
          1: send_simple(semg_pkg::REQ_CLEAR);
          2: send_simple(semg_pkg::REQ_SINGLE);
          default: send_simple(semg_pkg::REQ_TICK);
        endcase
      end
    end else if (kind == 6) begin
      send_simple(semg_pkg::REQ_HOME);
      ticks = $urandom_range(1, 60);
      for (int t = 0; t < ticks; t++) begin
        if ($urandom_range(0, 39) == 0) send_simple(semg_pkg::REQ_STOP);
        else send_simple(semg_pkg::REQ_TICK);
      end
    end else if (kind == 7) begin
      send_simple(semg_pkg::REQ_SINGLE);
    end else if (kind == 8) begin
      send_simple($urandom_range(0, 1) ? semg_pkg::REQ_STOP : semg_pkg::REQ_CLEAR);
    end else begin
      send_simple(3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    logic [3:0] masks [7];
    masks = '{4'hF, 4'h0, 4'h5, 4'hA, 4'h1, 4'h8, 4'hF};
    masks[6] = 4'($urandom);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0; in_duration_ms = '0;
    in_target_a = '0; in_target_b = '0; in_target_c = '0; in_target_d = '0;
    in_servo_index = '0; in_single_angle = '0;
    cfg_valid = 1'b0; cfg_enabled_mask = 4'hF;
    long_hold_req = 1'b0;
    sent_items = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: extremes, every request code and the special cases.
    send_req(semg_pkg::REQ_TICK, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_req(semg_pkg::REQ_MOVE, 16'd0, 8'd255, 8'd181, 8'd180, 8'd0, 3'd0, 9'd0);
    send_req(semg_pkg::REQ_MOVE, 16'd10, 8'd0, 8'd180, 8'd45, 8'd255, 3'd7, 9'h1FF);
    send_req(semg_pkg::REQ_MOVE, 16'd11, 8'd90, 8'd0, 8'd180, 8'd30, 3'd0, 9'd0);
    send_simple(semg_pkg::REQ_TICK);
    send_req(semg_pkg::REQ_MOVE, 16'd40, 8'd0, 8'd180, 8'd10, 8'd170, 3'd0, 9'd0);
    repeat (4) send_simple(semg_pkg::REQ_TICK);
    send_req(semg_pkg::REQ_MOVE, 16'd65535, 8'd180, 8'd0, 8'd180, 8'd0, 3'd0, 9'd0);
    send_simple(semg_pkg::REQ_TICK);
    send_simple(semg_pkg::REQ_STOP);
    send_simple(semg_pkg::REQ_TICK);
    send_req(semg_pkg::REQ_MOVE, 16'd5, 8'd1, 8'd2, 8'd3, 8'd4, 3'd0, 9'd0);
    send_simple(semg_pkg::REQ_HOME);
    send_simple(semg_pkg::REQ_STOP);
    send_simple(semg_pkg::REQ_TICK);
    send_simple(semg_pkg::REQ_CLEAR);
    send_req(semg_pkg::REQ_SINGLE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0, -9'sd256);
    send_req(semg_pkg::REQ_SINGLE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd1, 9'sd255);
    send_req(semg_pkg::REQ_SINGLE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd2, 9'sd180);
    send_req(semg_pkg::REQ_SINGLE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd3, 9'sd0);
    send_req(semg_pkg::REQ_SINGLE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd7, 9'sd10);
    send_simple(3'd6);
    send_simple(3'd7);

    // Random phases, each under its own enable mask.
    for (int p = 0; p < 7; p++) begin
      write_mask(masks[p]);
      if (p == 2) long_hold_req = 1'b1;
      while (sent_items < 25 + (p + 1) * 105) random_sequence();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
